// File: hw/rtl/d2u_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package d2u_pkg;

  // string limits and character codes
  localparam int unsigned MaxDigits = 78;
  localparam int unsigned CountW    = 7;
  localparam logic [7:0]  CharZero  = 8'h30;
  localparam logic [7:0]  CharNine  = 8'h39;

  // value geometry
  localparam int unsigned WordW    = 64;
  localparam int unsigned NumWords = 4;
  localparam int unsigned ValueW   = WordW * NumWords;
  localparam int unsigned WordIdxW = $clog2(NumWords);

  // queue between front and back
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  // input transfer
  typedef struct packed {
    logic [7:0] character;
    logic       terminator;
  } in_t;

  // result transfer
  typedef struct packed {
    logic [WordW-1:0] value_word;
    logic             valid_res;
    logic             last_word;
  } out_t;

  // classified item from front to back
  typedef struct packed {
    logic       terminator;
    logic       bad;
    logic [3:0] digit;
  } item_t;

  // finished value from back to output stage
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              ok;
  } snap_t;

endpackage

`default_nettype wire

// File: hw/rtl/d2u_front.sv
`timescale 1ns / 1ps
`default_nettype none

module d2u_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           accept_i,
  input  wire d2u_pkg::in_t   in_i,
  output d2u_pkg::item_t      item_o
);

  logic [d2u_pkg::CountW-1:0] count_q, count_d;
  logic                       lz_q, lz_d;
  logic                       is_digit;
  logic                       too_long;
  logic                       lz_err;
  logic [7:0]                 offset;

  // character classification
  assign offset   = in_i.character - d2u_pkg::CharZero;
  assign is_digit = (in_i.character >= d2u_pkg::CharZero) &&
                    (in_i.character <= d2u_pkg::CharNine);
  assign too_long = count_q >= d2u_pkg::CountW'(d2u_pkg::MaxDigits);
  assign lz_err   = (count_q != '0) && lz_q;

  always_comb begin
    item_o.terminator = in_i.terminator;
    item_o.digit      = offset[3:0];
    if (in_i.terminator) begin
      item_o.bad = (count_q == '0);
    end else begin
      item_o.bad = too_long || lz_err || !is_digit;
    end
  end

  // digit count and leading zero tracking
  always_comb begin
    count_d = count_q;
    lz_d    = lz_q;
    if (accept_i) begin
      if (in_i.terminator) begin
        count_d = '0;
        lz_d    = 1'b0;
      end else if (!too_long) begin
        if ((count_q == '0) && (in_i.character == d2u_pkg::CharZero)) begin
          lz_d = 1'b1;
        end
        count_d = count_q + d2u_pkg::CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      lz_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      lz_q    <= lz_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/d2u_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module d2u_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire d2u_pkg::item_t item_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output d2u_pkg::item_t      item_o,
  output logic                empty_o
);

  d2u_pkg::item_t                mem_q [d2u_pkg::FifoDepth];
  logic [d2u_pkg::FifoPtrW-1:0]  wptr_q, rptr_q;
  logic [d2u_pkg::FifoCntW-1:0]  cnt_q, cnt_d;
  logic                          do_push, do_pop;

  assign full_o  = cnt_q == d2u_pkg::FifoCntW'(d2u_pkg::FifoDepth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rptr_q];

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + d2u_pkg::FifoCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - d2u_pkg::FifoCntW'(1);
    end
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wptr_q <= wptr_q + d2u_pkg::FifoPtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + d2u_pkg::FifoPtrW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/d2u_back.sv
`timescale 1ns / 1ps
`default_nettype none

module d2u_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           avail_i,
  input  wire d2u_pkg::item_t item_i,
  output logic                take_o,
  input  wire logic           snap_ready_i,
  output logic                snap_load_o,
  output d2u_pkg::snap_t      snap_o
);

  logic [d2u_pkg::ValueW-1:0] acc_q, acc_d;
  logic                       err_q, err_d;
  logic [d2u_pkg::ValueW+3:0] sum;

  // a terminator waits for the output stage, a digit never waits
  assign take_o      = avail_i && (!item_i.terminator || snap_ready_i);
  assign snap_load_o = take_o && item_i.terminator;

  // acc*10 + digit as two shifted copies and the digit
  assign sum = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} +
               (d2u_pkg::ValueW+4)'(item_i.digit);

  always_comb begin
    snap_o.ok    = !err_q && !item_i.bad;
    snap_o.value = snap_o.ok ? acc_q : '0;
  end

  // accumulator and sticky error
  always_comb begin
    acc_d = acc_q;
    err_d = err_q;
    if (take_o) begin
      if (item_i.terminator) begin
        acc_d = '0;
        err_d = 1'b0;
      end else if (item_i.bad) begin
        err_d = 1'b1;
      end else if (!err_q) begin
        acc_d = sum[d2u_pkg::ValueW-1:0];
        if (sum[d2u_pkg::ValueW+3:d2u_pkg::ValueW] != 4'd0) begin
          err_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      err_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      err_q <= err_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/d2u_out.sv
`timescale 1ns / 1ps
`default_nettype none

module d2u_out (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_i,
  input  wire d2u_pkg::snap_t snap_i,
  output logic                ready_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output d2u_pkg::out_t       out_o
);

  logic [d2u_pkg::ValueW-1:0]   words_q;
  logic                         ok_q;
  logic                         busy_q;
  logic [d2u_pkg::WordIdxW-1:0] idx_q;
  logic                         do_pop;
  logic                         last;

  assign last    = idx_q == d2u_pkg::WordIdxW'(d2u_pkg::NumWords - 1);
  assign do_pop  = pop_i && busy_q;
  assign ready_o = !busy_q || (do_pop && last);
  assign empty_o = !busy_q;

  assign out_o.value_word = words_q[d2u_pkg::ValueW-1 -: d2u_pkg::WordW];
  assign out_o.valid_res  = ok_q;
  assign out_o.last_word  = last;

  // group control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      if (load_i) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (do_pop) begin
        idx_q <= idx_q + d2u_pkg::WordIdxW'(1);
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // word shifter, most significant word on the port
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      words_q <= snap_i.value;
      ok_q    <= snap_i.ok;
    end else if (do_pop) begin
      words_q <= {words_q[d2u_pkg::ValueW-d2u_pkg::WordW-1:0],
                  {d2u_pkg::WordW{1'b0}}};
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/decimal_to_u256_converter.sv
// ASCII decimal string to 256-bit unsigned value.
// Input channel: push_i/full_o carry one character per transfer in in_i;
// in_i.terminator ends the string and in_i.character is then ignored.
// Result channel: empty_o/pop_i; each terminator yields four results,
// value_word most significant 64 bits first, last_word on the fourth.
// valid_res is 1 when the string was a canonical decimal below 2^256
// (non-empty, digits only, no leading zero, at most 78 digits); else the
// words are zero.
// Throughput: one character per cycle while full_o is low, set by the
// 256-bit times-ten adder in the back end. Each string also yields four
// words, one per pop, so strings shorter than three characters run at the
// output rate. The first word of a string can be popped once its
// terminator has passed the front queue and then the snapshot register.
// A two-entry queue decouples the classifier from the accumulator; when
// the receiver stalls, the output stage holds its words, a following
// terminator waits in the queue, and full_o rises once the queue fills.
// Reset clears the digit count, flags, accumulator, queue and output stage.
`timescale 1ns / 1ps
`default_nettype none

module decimal_to_u256_converter (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  output logic               full_o,
  input  wire d2u_pkg::in_t  in_i,
  output logic               empty_o,
  input  wire logic          pop_i,
  output d2u_pkg::out_t      out_o
);

  d2u_pkg::item_t front_item, back_item;
  d2u_pkg::snap_t snap;
  logic           accept;
  logic           fifo_empty;
  logic           take;
  logic           snap_ready;
  logic           snap_load;

  assign accept = push_i && !full_o;

  // front: counting and classification
  d2u_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_i),
    .item_o   (front_item)
  );

  // queue between front and back
  d2u_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .item_i  (front_item),
    .full_o  (full_o),
    .pop_i   (take),
    .item_o  (back_item),
    .empty_o (fifo_empty)
  );

  // back: accumulator
  d2u_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .avail_i      (!fifo_empty),
    .item_i       (back_item),
    .take_o       (take),
    .snap_ready_i (snap_ready),
    .snap_load_o  (snap_load),
    .snap_o       (snap)
  );

  // result serializer
  d2u_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (snap_load),
    .snap_i  (snap),
    .ready_o (snap_ready),
    .pop_i   (pop_i),
    .empty_o (empty_o),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/d2u_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module d2u_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          empty_o,
  input wire logic          pop_i,
  input wire d2u_pkg::out_t out_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(out_o)))
    else $error("stalled result changed");

  // an invalid string gives zero words
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !out_o.valid_res) |-> (out_o.value_word == '0))
    else $error("invalid result with nonzero word");

  // the rest of a group follows at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && pop_i && !out_o.last_word) |=> !empty_o)
    else $error("result group broken off");

  // one verdict for a whole group
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && pop_i && !out_o.last_word) |=>
      (out_o.valid_res == $past(out_o.valid_res)))
    else $error("valid flag changed inside group");

endmodule

bind decimal_to_u256_converter d2u_checker u_d2u_checker (.*);

`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import d2u_pkg::*;

  localparam int unsigned RandomItems = 140;
  localparam int unsigned DrainCycles = 12;
  localparam string MaxText =
    "115792089237316195423570985008687907853269984665640564039457584007913129639935";
  localparam string OverText =
    "115792089237316195423570985008687907853269984665640564039457584007913129639936";

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  in_t  in_item = '0;
  logic pop = 1'b0;
  logic full;
  logic empty;
  out_t out_word;

  decimal_to_u256_converter u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .push_i (push),
    .full_o (full),
    .in_i   (in_item),
    .empty_o(empty),
    .pop_i  (pop),
    .out_o  (out_word)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #400_000;
    $display("TB_ERROR");
    $finish;
  end

  // converter state as the testbench sees it
  logic [ValueW-1:0] acc_value = '0;
  int unsigned       chars_taken = 0;
  bit                opened_with_zero = 1'b0;
  bit                string_bad = 1'b0;

  // words still to come out of the block, oldest first
  out_t        due_words[$];
  int unsigned word_mismatches = 0;

  // characters of the string being built, and transfer bookkeeping
  logic [7:0]  line_chars[$];
  int unsigned items_pushed = 0;
  bit          quiet = 1'b0;

  // directed strings
  typedef struct {
    string             text;
    bit                has_tail;
    logic [7:0]        tail;
    bit                typed;
    bit                exp_ok;
    logic [ValueW-1:0] exp_value;
  } line_case_t;
  line_case_t line_cases[$];

  function automatic void add_case(string text, bit has_tail, logic [7:0] tail,
                                   bit typed, bit exp_ok, logic [ValueW-1:0] exp_value);
    line_case_t row;
    row.text      = text;
    row.has_tail  = has_tail;
    row.tail      = tail;
    row.typed     = typed;
    row.exp_ok    = exp_ok;
    row.exp_value = exp_value;
    line_cases.push_back(row);
  endfunction

  function automatic string replicate_text(string unit, int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, unit};
    return s;
  endfunction

  // one character into the running value
  function automatic void take_char(logic [7:0] ch);
    logic [ValueW+3:0] scaled;
    if (chars_taken >= MaxDigits) begin
      string_bad = 1'b1;
      return;
    end
    if (chars_taken == 0) begin
      if (ch == CharZero) opened_with_zero = 1'b1;
    end else if (opened_with_zero) begin
      string_bad = 1'b1;
    end
    chars_taken++;
    if (ch < CharZero || ch > CharNine) string_bad = 1'b1;
    if (!string_bad) begin
      scaled = ({4'b0, acc_value} << 3) + ({4'b0, acc_value} << 1)
             + {{ValueW{1'b0}}, ch[3:0]};
      if (scaled[ValueW+3:ValueW] != 4'b0) string_bad = 1'b1;
      acc_value = scaled[ValueW-1:0];
    end
  endfunction

  // terminator: queue the four words, then start over
  function automatic void close_string(bit typed, bit typed_ok,
                                       logic [ValueW-1:0] typed_value);
    bit                ok;
    logic [ValueW-1:0] value;
    out_t              word;
    ok = !string_bad && chars_taken != 0;
    value = ok ? acc_value : '0;
    if (typed) begin
      ok    = typed_ok;
      value = typed_value;
    end
    for (int k = 0; k < NumWords; k++) begin
      word.value_word = value[ValueW-1-k*WordW -: WordW];
      word.valid_res  = ok;
      word.last_word  = (k == NumWords - 1);
      due_words.push_back(word);
    end
    acc_value        = '0;
    chars_taken      = 0;
    opened_with_zero = 1'b0;
    string_bad       = 1'b0;
  endfunction

  function automatic void load_text(string text);
    line_chars = {};
    for (int i = 0; i < text.len(); i++) line_chars.push_back(text[i]);
  endfunction

  // canonical digits: no leading zero unless the string is a lone digit
  function automatic void append_digits(int len);
    for (int i = 0; i < len; i++) begin
      if (i == 0 && len > 1) line_chars.push_back(CharZero + 8'($urandom_range(9, 1)));
      else line_chars.push_back(CharZero + 8'($urandom_range(9, 0)));
    end
  endfunction

  function automatic logic [7:0] non_digit();
    logic [7:0] b;
    do b = 8'($urandom_range(255, 0)); while (b >= CharZero && b <= CharNine);
    return b;
  endfunction

  // one input transfer, with an occasional gap before it
  task automatic push_item(in_t item);
    if (!quiet && $urandom_range(99, 0) < 7) begin
      push <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= item;
    @(posedge clk);
    while (full) @(posedge clk);
    items_pushed++;
  endtask

  // send line_chars and the terminator, predicting along the way
  task automatic send_line(bit typed, bit typed_ok, logic [ValueW-1:0] typed_value);
    in_t item;
    foreach (line_chars[i]) begin
      item.character  = line_chars[i];
      item.terminator = 1'b0;
      push_item(item);
      take_char(line_chars[i]);
    end
    item.character  = 8'($urandom);
    item.terminator = 1'b1;
    push_item(item);
    close_string(typed, typed_ok, typed_value);
  endtask

  function automatic void note_mismatch(string what, out_t want, out_t got);
    word_mismatches++;
    if (word_mismatches <= 10)
      $display("mismatch (%s): expected word %h valid %b last %b, got word %h valid %b last %b",
               what, want.value_word, want.valid_res, want.last_word,
               got.value_word, got.valid_res, got.last_word);
  endfunction

  // result side: pop with random stalls and check each transfer
  initial begin : drain_results
    out_t want;
    @(posedge rst_n);
    forever begin
      pop <= quiet || $urandom_range(99, 0) >= 7;
      @(posedge clk);
      if (pop && !empty) begin
        if (due_words.size() == 0) begin
          note_mismatch("no word expected", '0, out_word);
        end else begin
          want = due_words.pop_front();
          if (out_word.value_word !== want.value_word ||
              out_word.valid_res !== want.valid_res ||
              out_word.last_word !== want.last_word)
            note_mismatch("field", want, out_word);
        end
      end
    end
  end

  // stimulus
  initial begin : run_stimulus
    int unsigned random_start;
    int unsigned pick;
    int unsigned len;
    int unsigned spot;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed strings; expected value typed in where it is obvious
    add_case("", 1'b0, 8'h00, 1'b1, 1'b0, '0);
    add_case("0", 1'b0, 8'h00, 1'b1, 1'b1, '0);
    add_case("9", 1'b0, 8'h00, 1'b1, 1'b1, ValueW'(9));
    add_case("90", 1'b0, 8'h00, 1'b1, 1'b1, ValueW'(90));
    add_case("00", 1'b0, 8'h00, 1'b1, 1'b0, '0);
    add_case("0123", 1'b0, 8'h00, 1'b1, 1'b0, '0);
    add_case("12a4", 1'b0, 8'h00, 1'b1, 1'b0, '0);
    add_case("/", 1'b0, 8'h00, 1'b1, 1'b0, '0);
    add_case(":", 1'b0, 8'h00, 1'b1, 1'b0, '0);
    add_case("5", 1'b1, 8'h00, 1'b1, 1'b0, '0);
    add_case("", 1'b1, 8'hFF, 1'b1, 1'b0, '0);
    add_case("a9", 1'b0, 8'h00, 1'b1, 1'b0, '0);
    add_case(MaxText, 1'b0, 8'h00, 1'b1, 1'b1, '1);
    add_case(OverText, 1'b0, 8'h00, 1'b1, 1'b0, '0);
    add_case({"1", replicate_text("0", 78)}, 1'b0, 8'h00, 1'b1, 1'b0, '0);
    add_case("18446744073709551615", 1'b0, 8'h00, 1'b1, 1'b1,
             {{(ValueW-WordW){1'b0}}, {WordW{1'b1}}});
    add_case("12345678901234567890", 1'b0, 8'h00, 1'b0, 1'b0, '0);
    add_case("18446744073709551616", 1'b0, 8'h00, 1'b0, 1'b0, '0);

    foreach (line_cases[i]) begin
      load_text(line_cases[i].text);
      if (line_cases[i].has_tail) line_chars.push_back(line_cases[i].tail);
      send_line(line_cases[i].typed, line_cases[i].exp_ok, line_cases[i].exp_value);
    end

    // random strings, mostly canonical, some broken, a few long
    random_start = items_pushed;
    while (items_pushed - random_start < RandomItems) begin
      quiet <= (items_pushed - random_start >= 30) && (items_pushed - random_start < 120);
      line_chars = {};
      pick = $urandom_range(99, 0);
      if (pick < 40) begin
        append_digits($urandom_range(12, 1));
      end else if (pick < 54) begin
        append_digits($urandom_range(40, 13));
      end else if (pick < 57) begin
        // around the largest value: rewrite the last few digits
        load_text(MaxText);
        len = $urandom_range(3, 1);
        for (int j = 0; j < len; j++)
          line_chars[MaxDigits-1-j] = CharZero + 8'($urandom_range(9, 0));
      end else if (pick < 59) begin
        line_chars.push_back(CharZero + 8'd1);
        append_digits(0);
        for (int j = 1; j < MaxDigits; j++)
          line_chars.push_back(CharZero + 8'($urandom_range(9, 0)));
      end else if (pick < 60) begin
        append_digits($urandom_range(MaxDigits + 3, MaxDigits + 1));
      end else if (pick < 68) begin
        len = $urandom_range(6, 0);
        for (int j = 0; j < len; j++) line_chars.push_back(8'($urandom_range(255, 0)));
      end else if (pick < 75) begin
        line_chars.push_back(CharZero);
        len = $urandom_range(4, 1);
        for (int j = 0; j < len; j++)
          line_chars.push_back(CharZero + 8'($urandom_range(9, 0)));
      end else if (pick < 86) begin
        append_digits($urandom_range(10, 1));
        spot = $urandom_range(line_chars.size() - 1, 0);
        line_chars[spot] = non_digit();
      end else if (pick < 90) begin
        line_chars = {};
      end else begin
        append_digits($urandom_range(3, 1));
      end
      send_line(1'b0, 1'b0, '0);
    end

    quiet <= 1'b0;
    push  <= 1'b0;

    // drain
    while (due_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (word_mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
